[rtl/rcfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_pkg - shared types and constants of the RC receiver frame decoder
// Request layouts, command and register codes, scaling constants.
// ----------------------------------------------------------------------------
package rcfd_pkg;

	// Command codes of an input request
	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_END  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 15;
	localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_DOWN = 2'd2;

	// Register reset values
	localparam logic [14:0] DEADZONE_RST    = 15'd0;
	localparam logic [7:0]  TIMEOUT_RST     = 8'd50;
	localparam logic [1:0]  SWITCH_DOWN_RST = 2'd2;

	// Channel scaling: q = floor(mag * 16384 / 660) = (mag * RECIP_MULT) >> RECIP_SHIFT
	// (exact for mag <= 1024).
	localparam int unsigned CHAN_W      = 11;
	localparam int unsigned CHAN_COUNT  = 5;
	localparam logic [CHAN_W-1:0] CHAN_CENTER = 11'd1024;
	localparam int unsigned RECIP_W     = 23;
	localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd6507527;
	localparam int unsigned RECIP_SHIFT = 18;
	localparam int unsigned PROD_W      = CHAN_W + RECIP_W;
	localparam int unsigned MAG_Q_W     = 15;

	// Frame bytes fetched for a decode: bytes 0..5, then yaw bytes 16 and 17
	localparam int unsigned RD_COUNT = 8;
	localparam int unsigned RD_IDX_W = 3;
	localparam logic [4:0]  YAW_BYTE = 5'd16;

	function automatic logic [4:0] rd_addr(input logic [RD_IDX_W-1:0] idx);
		logic [4:0] addr;
		if (idx < 3'd6) begin
			addr = {2'b00, idx};
		end else begin
			addr = YAW_BYTE + {4'd0, idx[0]};
		end
		return addr;
	endfunction

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] yaw_wheel;
		logic [1:0]         sw_right;
		logic [1:0]         sw_left;
		logic               link_ok;
	} out_req_t;

endpackage
`default_nettype wire

[rtl/rcfd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rcfd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 18
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/rc_receiver_frame_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_unit - RC receiver frame decoder
// Stores received bytes of a remote-control frame in a RAM, decodes five
// stick channels and two switches at frame end, and reports link loss on
// watchdog ticks past the timeout.
// ----------------------------------------------------------------------------
//
//  port group   | dir | handshake             | content
//  -------------+-----+-----------------------+---------------------------------
//  in_*         | in  | in_valid / in_ready   | command, data_byte
//  out_*        | out | out_valid / out_ready | five Q2.14 channels, switches, link
//  cfg_*        | in  | cfg_valid / cfg_ready | register index, write data
//
//  Byte, short frame end and tick requests are taken back to back.
//  A frame end with a full frame runs the decode sequencer: eight RAM reads
//  (one read port, one byte a cycle), a state to capture the last byte, one
//  multiply stage and one output stage; the next request is taken when the
//  sequencer returns to idle, which waits while out is stalled.
//  Every tick waits for a free output slot; the output register lets bytes
//  keep flowing while a result waits.
//  Reset (arst_n low) clears counters, sequencer and output valid; the frame
//  RAM is not cleared, since a decode only reads bytes of the current frame.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_unit #(
	parameter int unsigned FRAME_BYTES = 18
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire rcfd_pkg::in_req_t                   in_req,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output rcfd_pkg::out_req_t                       out_req,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rcfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [rcfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned AW = $clog2(FRAME_BYTES);
	localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

	// Decode sequencer states
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_LAST = 5'b00100,
		S_MULT = 5'b01000,
		S_OUT  = 5'b10000
	} seq_state_t;

	seq_state_t st_q;

	// Configuration registers
	logic [14:0] deadzone_q;
	logic [7:0]  timeout_q;
	logic [1:0]  switch_down_q;

	// Counters
	logic [CW-1:0] byte_count_q;
	logic [7:0]    tick_q;

	// Read sweep
	logic [rcfd_pkg::RD_IDX_W-1:0] rd_idx_q;
	logic [rcfd_pkg::RD_IDX_W-1:0] rd_idx_s1;
	logic                          rd_vld_s1;
	logic [7:0]                    fr_byte_q [rcfd_pkg::RD_COUNT];

	// Channel arithmetic
	logic [rcfd_pkg::CHAN_W-1:0]  raw     [rcfd_pkg::CHAN_COUNT];
	logic [rcfd_pkg::PROD_W-1:0]  prod_s1 [rcfd_pkg::CHAN_COUNT];
	logic                         neg_s1  [rcfd_pkg::CHAN_COUNT];
	logic [rcfd_pkg::MAG_Q_W-1:0] mag_q   [rcfd_pkg::CHAN_COUNT];
	logic [15:0]                  chan_res[rcfd_pkg::CHAN_COUNT];

	// Output register
	logic               out_valid_q;
	rcfd_pkg::out_req_t out_req_q;
	rcfd_pkg::out_req_t out_next;
	logic               out_free;
	logic               out_push;

	// Request decode
	logic in_fire;
	logic is_byte;
	logic is_end;
	logic is_tick;
	logic frame_full;
	logic tick_expired;
	logic loss_fire;
	logic ram_we;
	logic [7:0] ram_rdata;
	logic [AW-1:0] ram_raddr;

	assign out_free = !out_valid_q || out_ready;
	assign is_byte  = in_req.command == rcfd_pkg::CMD_BYTE;
	assign is_end   = in_req.command == rcfd_pkg::CMD_END;
	assign is_tick  = in_req.command == rcfd_pkg::CMD_TICK;

	// Hold ticks while the output slot is busy; hold everything during a decode.
	assign in_ready = (st_q == S_IDLE) && (!is_tick || out_free);
	assign in_fire  = in_valid && in_ready;

	assign frame_full   = byte_count_q >= CW'(FRAME_BYTES);
	assign tick_expired = !(tick_q < timeout_q);
	assign loss_fire    = in_fire && is_tick && tick_expired;
	assign ram_we       = in_fire && is_byte && !frame_full;

	assign cfg_ready = 1'b1;

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q    <= rcfd_pkg::DEADZONE_RST;
			timeout_q     <= rcfd_pkg::TIMEOUT_RST;
			switch_down_q <= rcfd_pkg::SWITCH_DOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rcfd_pkg::REG_DEADZONE:    deadzone_q    <= cfg_data[14:0];
				rcfd_pkg::REG_TIMEOUT:     timeout_q     <= cfg_data[7:0];
				rcfd_pkg::REG_SWITCH_DOWN: switch_down_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Byte and tick counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			tick_q       <= '0;
		end else if (in_fire) begin
			if (ram_we) begin
				byte_count_q <= byte_count_q + CW'(1);
			end
			if (is_end) begin
				byte_count_q <= '0;
				if (frame_full) begin
					tick_q <= '0;
				end
			end
			if (is_tick && !tick_expired) begin
				tick_q <= tick_q + 8'd1;
			end
		end
	end

	// Frame RAM: write at the byte count, read by the decode sweep
	assign ram_raddr = AW'(rcfd_pkg::rd_addr(rd_idx_q));

	rcfd_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(byte_count_q[AW-1:0]),
		.wdata(in_req.data_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Decode sequencer: sweep reads, wait for last byte, multiply, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= st_q == S_READ;
			unique case (st_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					if (in_fire && is_end && frame_full) begin
						st_q <= S_READ;
					end
				end
				S_READ: begin
					rd_idx_q <= rd_idx_q + rcfd_pkg::RD_IDX_W'(1);
					if (rd_idx_q == rcfd_pkg::RD_IDX_W'(rcfd_pkg::RD_COUNT - 1)) begin
						st_q <= S_LAST;
					end
				end
				S_LAST: st_q <= S_MULT;
				S_MULT: st_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Capture read data in the cycle after each address
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		if (rd_vld_s1) begin
			fr_byte_q[rd_idx_s1] <= ram_rdata;
		end
	end

	// Unpack the little-endian bit stream into 11-bit channels
	assign raw[0] = {fr_byte_q[1][2:0], fr_byte_q[0]};
	assign raw[1] = {fr_byte_q[2][5:0], fr_byte_q[1][7:3]};
	assign raw[2] = {fr_byte_q[4][0], fr_byte_q[3], fr_byte_q[2][7:6]};
	assign raw[3] = {fr_byte_q[5][3:0], fr_byte_q[4][7:1]};
	assign raw[4] = {fr_byte_q[7][2:0], fr_byte_q[6]};

	// Multiply stage: magnitude around center times the 1/660 reciprocal
	always_ff @(posedge clk) begin
		if (st_q == S_MULT) begin
			for (int c = 0; c < rcfd_pkg::CHAN_COUNT; c++) begin
				neg_s1[c]  <= !raw[c][rcfd_pkg::CHAN_W-1];
				prod_s1[c] <= rcfd_pkg::PROD_W'(raw[c][rcfd_pkg::CHAN_W-1]
					? (raw[c] - rcfd_pkg::CHAN_CENTER)
					: (rcfd_pkg::CHAN_CENTER - raw[c])) * rcfd_pkg::PROD_W'(rcfd_pkg::RECIP_MULT);
			end
		end
	end

	// Output stage: drop the fraction, apply deadzone, restore sign
	always_comb begin
		for (int c = 0; c < rcfd_pkg::CHAN_COUNT; c++) begin
			mag_q[c] = prod_s1[c][rcfd_pkg::RECIP_SHIFT +: rcfd_pkg::MAG_Q_W];
			if (mag_q[c] < deadzone_q) begin
				mag_q[c] = '0;
			end
			chan_res[c] = neg_s1[c] ? (16'd0 - {1'b0, mag_q[c]}) : {1'b0, mag_q[c]};
		end
	end

	always_comb begin
		if (st_q == S_OUT) begin
			out_next.right_x   = chan_res[0];
			out_next.right_y   = chan_res[1];
			out_next.left_x    = chan_res[2];
			out_next.left_y    = chan_res[3];
			out_next.yaw_wheel = chan_res[4];
			out_next.sw_right  = fr_byte_q[5][5:4];
			out_next.sw_left   = fr_byte_q[5][7:6];
			out_next.link_ok   = 1'b1;
		end else begin
			out_next.right_x   = '0;
			out_next.right_y   = '0;
			out_next.left_x    = '0;
			out_next.left_y    = '0;
			out_next.yaw_wheel = '0;
			out_next.sw_right  = switch_down_q;
			out_next.sw_left   = switch_down_q;
			out_next.link_ok   = 1'b0;
		end
	end

	assign out_push = ((st_q == S_OUT) && out_free) || loss_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_req_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

	// Byte count never runs past the frame length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CW'(FRAME_BYTES))
		else $error("byte count past frame length");

	// A full frame end starts the read sweep
	a_decode_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_end && frame_full |=> st_q == S_READ)
		else $error("decode did not start");

	// The sweep leaves only after its last address
	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_LAST |-> $past(st_q) == S_READ
			&& $past(rd_idx_q) == rcfd_pkg::RD_IDX_W'(rcfd_pkg::RD_COUNT - 1))
		else $error("sweep ended early");

	// A link-loss result carries zero channels
	a_loss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_req_q.link_ok |-> out_req_q.right_x == 16'sd0
			&& out_req_q.right_y == 16'sd0 && out_req_q.left_x == 16'sd0
			&& out_req_q.left_y == 16'sd0 && out_req_q.yaw_wheel == 16'sd0)
		else $error("link loss with nonzero channel");

endmodule
`default_nettype wire
